/* rtl/core/u2c_pkg.sv */
// u2c_pkg: constants and mapping functions for the UTF-8 to Windows-1251 decoder.
// Holds the accented-letter fold table and the 0x80..0xBF code point table.
// No dependencies.
package u2c_pkg;

	localparam int TableSlots = 128;
	localparam int DefinedSlots = 64;

	localparam logic [20:0] CyrLow  = 21'h000410;
	localparam logic [20:0] CyrHigh = 21'h00044F;
	localparam logic [20:0] LatLow  = 21'h0000C0;
	localparam logic [20:0] LatHigh = 21'h0000FF;
	localparam logic [20:0] BmpMax  = 21'h00FFFF;

	localparam logic [511:0] FoldStr =
		"AAAAAAACEEEEIIIIDNOOOOOxOUUUUYPsaaaaaaaceeeeiiiidnooooo/ouuuuypy";

	localparam logic [15:0] HighHalf [DefinedSlots] = '{
		16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
		16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
		16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
		16'h0000, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
		16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
		16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
		16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
		16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
	};

	typedef logic [20:0] code_point_t;
	typedef logic [7:0]  glyph_t;

	function automatic logic [15:0] high_half(input logic [6:0] idx);
		logic [15:0] v;
		v = 16'h0000;
		if (idx < 7'(DefinedSlots)) begin
			v = HighHalf[idx[5:0]];
		end
		return v;
	endfunction

	function automatic glyph_t fold_letter(input logic [5:0] idx);
		logic [9:0] base;
		base = 10'(511) - {idx, 3'b000};
		return FoldStr[base -: 8];
	endfunction

	function automatic glyph_t map_code_point(input code_point_t cp, input int entries);
		glyph_t code;
		code = 8'h00;
		if (cp >= CyrLow && cp <= CyrHigh) begin
			code = {2'b11, cp[5:0] - 6'h10};
		end else if (cp >= LatLow && cp <= LatHigh) begin
			code = fold_letter(cp[5:0]);
		end else if (cp <= BmpMax) begin
			for (int i = 0; i < TableSlots; i++) begin
				if (i < entries && high_half(7'(i)) != 16'h0000
						&& {5'b00000, high_half(7'(i))} == cp) begin
					code = {1'b1, 7'(i)};
				end
			end
		end
		return code;
	endfunction

endpackage

/* rtl/core/u2c_stream_if.sv */
// u2c_byte_if / u2c_glyph_if: valid/ready stream channels of the decoder.
// A transfer happens on a rising edge with valid and ready both high.
// Depends on u2c_pkg.
interface u2c_byte_if import u2c_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	modport source (output valid, output byte_in, input ready);
	modport sink   (input valid, input byte_in, output ready);
endinterface

interface u2c_glyph_if import u2c_pkg::*; ();
	logic   valid;
	logic   ready;
	glyph_t glyph_code;
	modport source (output valid, output glyph_code, input ready);
	modport sink   (input valid, input glyph_code, output ready);
endinterface

/* rtl/core/utf8_to_cp1251_decoder_core.sv */
// utf8_to_cp1251_decoder_core: UTF-8 byte stream to Windows-1251 display codes.
// Depends on u2c_pkg and the channel interfaces in u2c_stream_if.sv.
//
// Usage:
//   byte_ch carries one raw UTF-8 byte per transfer; glyph_ch returns exactly
//   one display code per accepted byte, in order. Code 0 means nothing to draw
//   (continuation still expected, stray continuation, invalid lead byte or an
//   unmapped code point). ASCII passes through and aborts a pending sequence.
//   Path: an accepted byte is held in the input register, and its code is then registered in the result register.
//   Throughput: one byte per cycle unless glyph_ch stalls; the input register
//   and the result register each hold one item, and the decode plus table
//   lookup sits between them.
//   Stalls: when glyph_ch.ready is low the result register holds; byte_ch
//   keeps accepting until the input register is also full, then ready drops.
//   Reset: arst_n clears both pipeline valids, the pending continuation count
//   and the collected code point.
//   MAP_ENTRIES limits how many slots of the 0x80..0xBF table are searched.
module utf8_to_cp1251_decoder_core import u2c_pkg::*; #(
	parameter int MAP_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	u2c_byte_if.sink    byte_ch,
	u2c_glyph_if.source glyph_ch
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	glyph_t      code_s2;
	logic [1:0]  pend_q;
	code_point_t acc_q;

	logic        advance;
	logic [1:0]  pend_nxt;
	code_point_t acc_nxt;
	glyph_t      code_nxt;

	assign advance        = !valid_s2 || glyph_ch.ready;
	assign byte_ch.ready  = !valid_s1 || advance;
	assign glyph_ch.valid = valid_s2;
	assign glyph_ch.glyph_code = code_s2;

	always_comb begin
		pend_nxt = pend_q;
		acc_nxt  = acc_q;
		code_nxt = 8'h00;
		if (!byte_s1[7]) begin
			pend_nxt = 2'd0;
			code_nxt = byte_s1;
		end else if (byte_s1[7:6] == 2'b10) begin
			if (pend_q != 2'd0) begin
				acc_nxt  = {acc_q[14:0], byte_s1[5:0]};
				pend_nxt = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					code_nxt = map_code_point({acc_q[14:0], byte_s1[5:0]}, MAP_ENTRIES);
				end
			end
		end else if (byte_s1[7:5] == 3'b110) begin
			acc_nxt  = {16'h0000, byte_s1[4:0]};
			pend_nxt = 2'd1;
		end else if (byte_s1[7:4] == 4'b1110) begin
			acc_nxt  = {17'h00000, byte_s1[3:0]};
			pend_nxt = 2'd2;
		end else if (byte_s1[7:3] == 5'b11110) begin
			acc_nxt  = {18'h00000, byte_s1[2:0]};
			pend_nxt = 2'd3;
		end else begin
			pend_nxt = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pend_q   <= 2'd0;
			acc_q    <= '0;
		end else begin
			if (byte_ch.ready) begin
				valid_s1 <= byte_ch.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					pend_q <= pend_nxt;
					acc_q  <= acc_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			byte_s1 <= byte_ch.byte_in;
		end
		if (advance && valid_s1) begin
			code_s2 <= code_nxt;
		end
	end

endmodule

/* rtl/core/u2c_checker.sv */
// u2c_checker: port-level assertions for utf8_to_cp1251_decoder_core.
// Bound to utf8_to_cp1251_decoder_core by the bind below; depends on u2c_pkg.
module u2c_checker import u2c_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input glyph_t glyph_code
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(glyph_code))
		else $error("stalled result changed");

	// input only backs up when both stages are full
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with free output stage");

	// 0x98 is unassigned and must never be produced
	a_no_unassigned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> glyph_code != 8'h98)
		else $error("unassigned code emitted");

	// no output without a prior transfer in
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready, 2) && $past(in_valid, 2) || $past(out_valid))
		else $error("result without input");

endmodule

bind utf8_to_cp1251_decoder_core u2c_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (byte_ch.valid),
	.in_ready   (byte_ch.ready),
	.out_valid  (glyph_ch.valid),
	.out_ready  (glyph_ch.ready),
	.glyph_code (glyph_ch.glyph_code)
);
